### hdl/nts_pkg.sv
// Shared types, constants and note tables for the note tone sequencer.
// No dependencies; imported by every module of the block.
package nts_pkg;

  // Sequence store geometry
  localparam int SEQ_DEPTH = 64;
  localparam int SEQ_AW    = $clog2(SEQ_DEPTH);
  localparam logic [6:0] SEQ_DEPTH_L = 7'(SEQ_DEPTH);

  // Note numbering
  localparam logic [5:0] REST_NOTE  = 6'd35;
  localparam int         NOTE_COUNT = 36;

  // Pin pair idle pattern
  localparam logic [1:0] PAIR_IDLE = 2'b10;
  localparam logic [1:0] PAIR_ALL  = 2'b11;

  localparam logic [7:0] TOP_TABLE [NOTE_COUNT] = '{
    8'd252, 8'd239, 8'd226, 8'd213, 8'd201, 8'd190, 8'd179, 8'd169, 8'd160,
    8'd151, 8'd142, 8'd134, 8'd127, 8'd120, 8'd113, 8'd106, 8'd101, 8'd95,
    8'd90,  8'd85,  8'd80,  8'd75,  8'd71,  8'd67,  8'd63,  8'd60,  8'd56,
    8'd53,  8'd50,  8'd47,  8'd45,  8'd42,  8'd40,  8'd38,  8'd36,  8'd253
  };

  localparam logic [7:0] REP_TABLE [NOTE_COUNT] = '{
    8'd25,  8'd26,  8'd28,  8'd29,  8'd31,  8'd33,  8'd35,  8'd37,  8'd39,
    8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd55,  8'd59,  8'd62,  8'd66,
    8'd70,  8'd74,  8'd78,  8'd83,  8'd88,  8'd93,  8'd99,  8'd105, 8'd111,
    8'd117, 8'd124, 8'd132, 8'd140, 8'd148, 8'd157, 8'd166, 8'd176, 8'd25
  };

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_PLAY  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_START = 3'd3,
    CMD_STOP  = 3'd4
  } nts_cmd_e;

  // Input beat
  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] note;
    logic [7:0] duration;
    logic [5:0] entry_index;
    logic [6:0] seq_length;
    logic [7:0] cut_count;
  } nts_in_t;

  // Result beat
  typedef struct packed {
    logic       tone_out;
    logic [1:0] pair_out;
    logic       playing;
    logic       seq_active;
    logic       note_end;
  } nts_out_t;

  // One sequence store entry
  typedef struct packed {
    logic [5:0] note;
    logic [7:0] len;
  } nts_entry_t;

  // Store write request
  typedef struct packed {
    logic              en;
    logic [SEQ_AW-1:0] addr;
    nts_entry_t        data;
  } nts_wr_t;

  // Timer and sequencer state
  typedef struct packed {
    logic [7:0]  tick;
    logic [7:0]  top;
    logic [15:0] left;
    logic        toggle;
    logic        count_on;
    logic [1:0]  drive;
    logic        tone;
    logic [1:0]  pair;
    logic        run;
    logic [6:0]  pos;
    logic [6:0]  len;
    logic [7:0]  cut;
  } nts_state_t;

  localparam nts_state_t STATE_RESET = '{
    tick: 8'd0, top: 8'd0, left: 16'd0, toggle: 1'b0, count_on: 1'b0,
    drive: 2'b00, tone: 1'b0, pair: PAIR_IDLE, run: 1'b0, pos: 7'd0,
    len: 7'd0, cut: 8'd0
  };

  // Compare top of a note, zero for indexes past the rest
  function automatic logic [7:0] note_top(input logic [5:0] n);
    logic [7:0] r;
    r = 8'd0;
    if (n <= REST_NOTE) r = TOP_TABLE[n];
    return r;
  endfunction

  // Matches per 100 ms of a note, zero for indexes past the rest
  function automatic logic [7:0] note_rep(input logic [5:0] n);
    logic [7:0] r;
    r = 8'd0;
    if (n <= REST_NOTE) r = REP_TABLE[n];
    return r;
  endfunction

endpackage

### hdl/nts_seq_store.sv
// Sequence store: note and length per slot, one write and one registered read.
// Depends on nts_pkg for the entry and write types.
module nts_seq_store
  import nts_pkg::*;
(
  input  logic              clk_i,
  input  nts_wr_t           wr_i,
  input  logic [SEQ_AW-1:0] rd_addr_i,
  output nts_entry_t        rd_data_o
);

  nts_entry_t mem_q [SEQ_DEPTH];
  nts_entry_t rd_q;

  // Write the slot
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read the next slot, passing a same-cycle write straight through
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      rd_q <= wr_i.data;
    end else begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### hdl/nts_core.sv
// Tone timer and sequencer step: one command beat per cycle while fire_i is set, against held state.
// Depends on nts_pkg; reads the prefetched store entry from nts_seq_store.
module nts_core
  import nts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  nts_in_t           in_i,
  input  logic              use_pin_pair_i,
  input  nts_entry_t        entry_i,
  output nts_wr_t           wr_o,
  output logic [SEQ_AW-1:0] rd_addr_o,
  output nts_out_t          res_o
);

  nts_state_t st_q, st_d;
  logic       ended;
  logic [5:0] src_note;
  logic [7:0] src_dur;
  logic [7:0] src_top;
  logic [15:0] src_count;
  logic [6:0] pos_next;
  logic [6:0] rd_pos;

  // Load a note or rest into the timer; notes past the rest only re-arm the pin pair
  function automatic nts_state_t start_note(input nts_state_t s, input logic [5:0] n,
                                            input logic [7:0] top,
                                            input logic [15:0] cnt);
    nts_state_t r;
    r = s;
    r.pair  = PAIR_IDLE;
    r.drive = PAIR_ALL;
    if (n < REST_NOTE) begin
      r.toggle   = 1'b1;
      r.left     = cnt;
      r.top      = top;
      r.count_on = 1'b1;
    end else if (n == REST_NOTE) begin
      r.drive    = 2'b00;
      r.toggle   = 1'b0;
      r.left     = cnt;
      r.top      = top;
      r.count_on = 1'b1;
    end
    return r;
  endfunction

  // Pick the note source: command beat for play, store entry otherwise
  always_comb begin
    if (in_i.cmd == CMD_PLAY) begin
      src_note = in_i.note;
      src_dur  = in_i.duration;
    end else begin
      src_note = entry_i.note;
      src_dur  = entry_i.len;
    end
    src_top   = note_top(src_note);
    src_count = 16'(note_rep(src_note)) * 16'(src_dur);
  end

  assign pos_next = st_q.pos + 7'd1;

  // Step the state for one command beat
  always_comb begin
    st_d  = st_q;
    ended = 1'b0;
    wr_o  = '0;
    if (fire_i) begin
      case (in_i.cmd)
        CMD_TICK: begin
          if (st_q.top != 8'd0) begin
            if (st_q.tick >= st_q.top) begin
              st_d.tick = 8'd0;
              st_d.tone = st_q.tone ^ st_q.toggle;
              if (st_q.count_on) begin
                if (use_pin_pair_i) st_d.pair = st_q.pair ^ st_q.drive;
                if (st_q.left != 16'd0) st_d.left = st_q.left - 16'd1;
                if ((st_q.cut != 8'd0) && (st_d.left == {8'd0, st_q.cut})) begin
                  st_d.toggle = 1'b0;
                  st_d.drive  = 2'b00;
                end
                if (st_d.left == 16'd0) begin
                  ended       = 1'b1;
                  st_d.toggle = 1'b1;
                  st_d.tick   = 8'd0;
                  if (st_q.run) begin
                    st_d.pos = pos_next;
                    if (pos_next < st_q.len) begin
                      st_d = start_note(st_d, src_note, src_top, src_count);
                    end else begin
                      st_d.run      = 1'b0;
                      st_d.top      = 8'd0;
                      st_d.count_on = 1'b0;
                      st_d.pair     = 2'b00;
                    end
                  end else begin
                    st_d.top      = 8'd0;
                    st_d.count_on = 1'b0;
                    st_d.pair     = 2'b00;
                  end
                end
              end
            end else begin
              st_d.tick = st_q.tick + 8'd1;
            end
          end
        end
        CMD_PLAY: begin
          st_d = start_note(st_q, src_note, src_top, src_count);
        end
        CMD_WRITE: begin
          if (int'(in_i.entry_index) < SEQ_DEPTH) begin
            wr_o.en        = 1'b1;
            wr_o.addr      = SEQ_AW'(in_i.entry_index);
            wr_o.data.note = in_i.note;
            wr_o.data.len  = in_i.duration;
          end
        end
        CMD_START: begin
          if (!st_q.run) begin
            st_d.cut = in_i.cut_count;
            st_d.run = 1'b1;
            st_d.len = (in_i.seq_length > SEQ_DEPTH_L) ? SEQ_DEPTH_L : in_i.seq_length;
            st_d.pos = 7'd0;
            st_d     = start_note(st_d, src_note, src_top, src_count);
          end
        end
        CMD_STOP: begin
          st_d.top      = 8'd0;
          st_d.count_on = 1'b0;
          st_d.pair     = 2'b00;
          st_d.run      = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Prefetch the entry the next step may start: slot 0 when idle, else the following slot
  assign rd_pos    = st_d.run ? (st_d.pos + 7'd1) : 7'd0;
  assign rd_addr_o = rd_pos[SEQ_AW-1:0];

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else begin
      st_q <= st_d;
    end
  end

  // Result of this beat
  assign res_o.tone_out   = st_d.tone;
  assign res_o.pair_out   = st_d.pair;
  assign res_o.playing    = st_d.count_on && (st_d.top != 8'd0);
  assign res_o.seq_active = st_d.run;
  assign res_o.note_end   = ended;

`ifndef NO_ASSERTIONS
  a_end_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended |-> (fire_i && (in_i.cmd == CMD_TICK)))
    else $error("note end outside a tick beat");

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.len <= SEQ_DEPTH_L)
    else $error("sequence length above store depth");

  a_stopped_timer_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (in_i.cmd == CMD_TICK) && (st_q.top == 8'd0)) |=> $stable(st_q.tick))
    else $error("tick counter moved while timer stopped");
`endif

endmodule

### hdl/note_tone_sequencer.sv
// Top level of the note tone sequencer: input register, step core, store, result register.
// Depends on nts_pkg, nts_core and nts_seq_store.
//
// Square-wave note generator with a 64-slot sequence store. Every command beat
// (tick, play, write slot, start, stop) yields exactly one result beat carrying
// the tone level, pin pair levels, playing, sequence-active and note-end flags.
// A beat passes through an input register and one pass of step logic into the
// result register, from which its result is presented, and one beat is taken
// every cycle while the result side does not stall. The store read is registered
// and addressed from the next state, so the next slot is always ready when a
// note ends. The use_pin_pair register is written through cfg_we_i/cfg_data_i;
// the user writes it only while idle, as the block does not enforce this.
module note_tone_sequencer
  import nts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  nts_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output nts_out_t out_data_o,
  input  logic     cfg_we_i,
  input  logic     cfg_data_i
);

  logic              in_valid_q;
  nts_in_t           in_q;
  logic              out_valid_q;
  nts_out_t          out_q;
  logic              use_pin_pair_q;
  logic              advance;
  logic              fire;
  logic              in_take;
  nts_wr_t           wr;
  logic [SEQ_AW-1:0] rd_addr;
  nts_entry_t        entry;
  nts_out_t          res;

  // Handshake: step when the result register is free or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_pin_pair_q <= 1'b0;
    end else if (cfg_we_i) begin
      use_pin_pair_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  nts_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .in_i           (in_q),
    .use_pin_pair_i (use_pin_pair_q),
    .entry_i        (entry),
    .wr_o           (wr),
    .rd_addr_o      (rd_addr),
    .res_o          (res)
  );

  nts_seq_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (entry)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### bench/nts_level_check.sv
// Result checker for the note tone sequencer bench: predicts every result beat
// from the accepted command beats and compares it field by field.
// Depends on nts_pkg for the beat types, note tables and command codes.
module nts_level_check
  import nts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  nts_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  nts_out_t out_data_i,
  input  logic     cfg_we_i,
  input  logic     cfg_data_i,
  output int       fail_count_o,
  output int       outstanding_o,
  output int       note_ends_o
);

  localparam int REPORT_LIMIT = 10;

  // Predicted timer and sequencer state
  logic [7:0]  tick_q;
  logic [7:0]  top_q;
  logic [15:0] left_q;
  logic        toggle_q;
  logic        count_on_q;
  logic [1:0]  drive_q;
  logic        tone_q;
  logic [1:0]  pair_q;
  logic        run_q;
  logic [6:0]  pos_q;
  logic [6:0]  len_q;
  logic [7:0]  cut_q;
  logic        pin_pair_q;
  logic [5:0]  slot_note [SEQ_DEPTH];
  logic [7:0]  slot_len  [SEQ_DEPTH];

  nts_out_t    levels_due [$];
  nts_out_t    want;
  int          fails;
  int          ends;
  int          checked;

  // Arm a note: tones toggle, the rest only counts, notes past the rest re-arm the pair
  task automatic load_note(input logic [5:0] n, input logic [7:0] d);
    pair_q  = PAIR_IDLE;
    drive_q = PAIR_ALL;
    if (n <= REST_NOTE) begin
      toggle_q   = (n != REST_NOTE);
      if (n == REST_NOTE) drive_q = 2'b00;
      left_q     = 16'(REP_TABLE[n]) * 16'(d);
      top_q      = TOP_TABLE[n];
      count_on_q = 1'b1;
    end
  endtask

  task automatic silence_timer();
    top_q      = 8'd0;
    count_on_q = 1'b0;
    pair_q     = 2'b00;
  endtask

  task automatic play_slot(input logic [6:0] pos);
    if (pos < SEQ_DEPTH) load_note(slot_note[pos[5:0]], slot_len[pos[5:0]]);
  endtask

  // One compare match: toggle, count down, mute at the cut point, advance the sequence
  task automatic count_match(output logic ended);
    ended  = 1'b0;
    tone_q = tone_q ^ toggle_q;
    if (count_on_q) begin
      if (pin_pair_q) pair_q = pair_q ^ drive_q;
      if (left_q != 16'd0) left_q = left_q - 16'd1;
      if (cut_q != 8'd0 && left_q == 16'(cut_q)) begin
        toggle_q = 1'b0;
        drive_q  = 2'b00;
      end
      if (left_q == 16'd0) begin
        ended    = 1'b1;
        toggle_q = 1'b1;
        tick_q   = 8'd0;
        if (run_q) begin
          pos_q = pos_q + 7'd1;
          if (pos_q < len_q) begin
            play_slot(pos_q);
          end else begin
            run_q = 1'b0;
            silence_timer();
          end
        end else begin
          silence_timer();
        end
      end
    end
  endtask

  // Apply one command beat and work out the levels it leaves on the outputs
  task automatic predict_levels(input nts_in_t b, output nts_out_t r);
    logic ended;
    ended = 1'b0;
    case (b.cmd)
      CMD_TICK: begin
        if (top_q != 8'd0) begin
          if (tick_q >= top_q) begin
            tick_q = 8'd0;
            count_match(ended);
          end else begin
            tick_q = tick_q + 8'd1;
          end
        end
      end
      CMD_PLAY: load_note(b.note, b.duration);
      CMD_WRITE: begin
        slot_note[b.entry_index] = b.note;
        slot_len[b.entry_index]  = b.duration;
      end
      CMD_START: begin
        // a start while a sequence runs is dropped
        if (!run_q) begin
          cut_q = b.cut_count;
          run_q = 1'b1;
          len_q = (b.seq_length > SEQ_DEPTH_L) ? SEQ_DEPTH_L : b.seq_length;
          pos_q = 7'd0;
          play_slot(7'd0);
        end
      end
      CMD_STOP: begin
        silence_timer();
        run_q = 1'b0;
      end
      default: ;
    endcase
    r.tone_out   = tone_q;
    r.pair_out   = pair_q;
    r.playing    = count_on_q && (top_q != 8'd0);
    r.seq_active = run_q;
    r.note_end   = ended;
  endtask

  // Predict on accepted command beats, compare on accepted result beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     = 8'd0;
      top_q      = 8'd0;
      left_q     = 16'd0;
      toggle_q   = 1'b0;
      count_on_q = 1'b0;
      drive_q    = 2'b00;
      tone_q     = 1'b0;
      pair_q     = PAIR_IDLE;
      run_q      = 1'b0;
      pos_q      = 7'd0;
      len_q      = 7'd0;
      cut_q      = 8'd0;
      pin_pair_q = 1'b0;
      fails      = 0;
      ends       = 0;
      checked    = 0;
      levels_due.delete();
    end else begin
      if (cfg_we_i) pin_pair_q = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        predict_levels(in_data_i, want);
        if (want.note_end) ends++;
        levels_due.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (levels_due.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("ERROR: result beat %0d (%h) arrived with nothing expected",
                     checked, out_data_i);
        end else begin
          want = levels_due.pop_front();
          if (out_data_i.tone_out !== want.tone_out || out_data_i.pair_out !== want.pair_out ||
              out_data_i.playing !== want.playing || out_data_i.seq_active !== want.seq_active ||
              out_data_i.note_end !== want.note_end) begin
            fails++;
            if (fails <= REPORT_LIMIT)
              $display({"ERROR: result beat %0d expected/actual: tone %b/%b pair %b/%b ",
                        "playing %b/%b seq %b/%b end %b/%b"}, checked,
                       want.tone_out, out_data_i.tone_out, want.pair_out, out_data_i.pair_out,
                       want.playing, out_data_i.playing, want.seq_active,
                       out_data_i.seq_active, want.note_end, out_data_i.note_end);
          end
        end
      end
    end
    fail_count_o  <= fails;
    outstanding_o <= levels_due.size();
    note_ends_o   <= ends;
  end

endmodule

### bench/testbench.sv
// Top of the note tone sequencer bench: clock, reset, command stimulus, result
// stalls and the verdict. Depends on nts_pkg, note_tone_sequencer and nts_level_check.
module testbench;
  import nts_pkg::*;

  localparam logic [5:0] HIGH_NOTE   = REST_NOTE - 6'd1;
  localparam int         PHASE_BEATS = 260;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  nts_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  nts_out_t out_data;
  logic     cfg_we;
  logic     cfg_data;

  int       fail_count;
  int       outstanding;
  int       note_ends;
  bit       calm;
  bit       written [SEQ_DEPTH];
  int       beats_sent;
  int       starts_sent;
  int       seen;
  int       hold_left;
  bit       hold_done;
  bit       leftover;

  note_tone_sequencer DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  nts_level_check level_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding),
    .note_ends_o  (note_ends)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the whole run
  initial begin
    #2000000;
    $display("ERROR: run did not finish in time");
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, one long hold-off once the run is under way
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) seen++;
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && seen >= 450) begin
        hold_done = 1'b1;
        hold_left = 120;
      end
      out_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < 25);
    end
  end

  // Count of store slots written without a hole from slot zero
  function automatic int slots_ready();
    int n;
    n = 0;
    while (n < SEQ_DEPTH && written[n]) n++;
    return n;
  endfunction

  // Mostly high tones so that notes end within a few dozen ticks
  function automatic logic [5:0] pick_note();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 6'($urandom_range(HIGH_NOTE, HIGH_NOTE - 6'd7));
    if (r < 75) return REST_NOTE;
    if (r < 90) return 6'($urandom_range(REST_NOTE));
    return 6'($urandom_range(63, REST_NOTE + 6'd1));
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 75) return 8'd0;
    if (r < 90) return 8'd1;
    return 8'($urandom);
  endfunction

  // Beat with the given command and random filler in every other field
  function automatic nts_in_t fresh_beat(input nts_cmd_e c);
    nts_in_t b;
    b.cmd         = c;
    b.note        = 6'($urandom);
    b.duration    = 8'($urandom);
    b.entry_index = 6'($urandom);
    b.seq_length  = 7'($urandom);
    b.cut_count   = 8'($urandom);
    return b;
  endfunction

  // Offer one beat, idling at random first, and hold it until accepted
  task automatic send_beat(input nts_in_t b);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Keep starts within written slots, then send
  task automatic issue(input nts_in_t b);
    int ready;
    ready = slots_ready();
    if (b.cmd == CMD_START) begin
      if (ready == 0) begin
        b.cmd         = CMD_WRITE;
        b.entry_index = 6'd0;
      end else begin
        if (ready < SEQ_DEPTH && b.seq_length > ready)
          b.seq_length = 7'($urandom_range(ready));
        starts_sent++;
      end
    end
    if (b.cmd == CMD_WRITE) written[b.entry_index] = 1'b1;
    send_beat(b);
  endtask

  // Run of ticks with the odd note or slot write slipped in
  task automatic send_ticks(input int n);
    nts_in_t b;
    repeat (n) begin
      b = fresh_beat(CMD_TICK);
      if ($urandom_range(99) < 3) begin
        b.cmd      = $urandom_range(1) ? CMD_PLAY : CMD_WRITE;
        b.note     = pick_note();
        b.duration = pick_length();
      end
      issue(b);
    end
  endtask

  // Stop offering until every expected result beat is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pin_pair(input logic v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    nts_in_t b;
    int      phase;
    int      k;
    int      count;
    int      target;
    int      wait_cycles;
    bit      mute;
    bit      paused;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= 1'b0;
    calm     <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_pin_pair(1'b1);

    // Directed: tick on a stopped timer with every field at its top
    b = fresh_beat(CMD_TICK);
    b.note = '1; b.duration = '1; b.entry_index = '1; b.seq_length = '1; b.cut_count = '1;
    issue(b);
    // unknown command codes
    for (k = int'(CMD_STOP) + 1; k < (1 << $bits(nts_cmd_e)); k++) begin
      b = fresh_beat(CMD_TICK);
      b.cmd = 3'(k);
      issue(b);
    end
    // store edges: highest tone, rest, lowest tone, last slot
    b = fresh_beat(CMD_WRITE); b.entry_index = 6'd0; b.note = HIGH_NOTE; b.duration = 8'd0;
    issue(b);
    b = fresh_beat(CMD_WRITE); b.entry_index = 6'd1; b.note = REST_NOTE; b.duration = 8'd0;
    issue(b);
    b = fresh_beat(CMD_WRITE); b.entry_index = 6'd2; b.note = 6'd0; b.duration = 8'd255;
    issue(b);
    b = fresh_beat(CMD_WRITE); b.entry_index = 6'd63; b.note = 6'd63; b.duration = 8'd255;
    issue(b);
    // zero-length sequence still plays slot zero; a second start is dropped
    b = fresh_beat(CMD_START); b.seq_length = 7'd0; b.cut_count = 8'd0;
    issue(b);
    send_ticks(3);
    b = fresh_beat(CMD_START); b.seq_length = 7'd3; b.cut_count = 8'd255;
    issue(b);
    // notes past the rest only re-arm the pair
    b = fresh_beat(CMD_PLAY); b.note = REST_NOTE + 6'd1;
    issue(b);
    b = fresh_beat(CMD_PLAY); b.note = 6'd63;
    issue(b);
    // rest and lowest tone at the longest duration
    b = fresh_beat(CMD_PLAY); b.note = REST_NOTE; b.duration = 8'd255;
    issue(b);
    b = fresh_beat(CMD_PLAY); b.note = 6'd0; b.duration = 8'd255;
    issue(b);
    issue(fresh_beat(CMD_STOP));
    // cut point set by a start carries over to a played note
    b = fresh_beat(CMD_START); b.seq_length = 7'd2; b.cut_count = 8'd255;
    issue(b);
    send_ticks(2);
    issue(fresh_beat(CMD_STOP));
    b = fresh_beat(CMD_PLAY); b.note = HIGH_NOTE; b.duration = 8'd1;
    issue(b);
    send_ticks(2);
    issue(fresh_beat(CMD_STOP));

    // Random phases, alternating the pin pair setting
    for (phase = 0; phase < 4; phase++) begin
      drain();
      set_pin_pair(phase[0]);
      calm   <= (phase == 1);
      target = beats_sent + PHASE_BEATS;
      paused = 1'b0;
      // fill the whole store once so long starts saturate
      if (phase == 2) begin
        issue(fresh_beat(CMD_STOP));
        for (k = 0; k < SEQ_DEPTH; k++) begin
          b = fresh_beat(CMD_WRITE);
          b.entry_index = 6'(k); b.note = pick_note(); b.duration = pick_length();
          issue(b);
        end
        b = fresh_beat(CMD_START); b.seq_length = 7'($urandom_range(127, SEQ_DEPTH));
        issue(b);
        send_ticks(40);
      end
      while (beats_sent < target) begin
        if (phase == 3 && !paused && beats_sent > target - PHASE_BEATS / 2) begin
          drain();
          paused = 1'b1;
        end
        k = $urandom_range(99);
        if (k < 55) begin
          // well-formed sequence: fill the first slots, start, then let it run
          if ($urandom_range(99) < 70) issue(fresh_beat(CMD_STOP));
          count = $urandom_range(4, 1);
          mute  = ($urandom_range(99) < 25);
          for (k = 0; k < count; k++) begin
            b = fresh_beat(CMD_WRITE);
            b.entry_index = 6'(k); b.note = pick_note(); b.duration = pick_length();
            if (mute && k == 0) begin
              b.note     = HIGH_NOTE;
              b.duration = 8'd1;
            end
            issue(b);
          end
          b = fresh_beat(CMD_START);
          if ($urandom_range(9) != 0) b.seq_length = 7'(count);
          if (mute) b.cut_count = 8'(REP_TABLE[HIGH_NOTE] - $urandom_range(2, 1));
          else if ($urandom_range(99) < 60) b.cut_count = 8'd0;
          issue(b);
          send_ticks($urandom_range(220, 40));
        end else if (k < 75) begin
          // single note then ticks
          b = fresh_beat(CMD_PLAY); b.note = pick_note(); b.duration = pick_length();
          issue(b);
          send_ticks($urandom_range(120, 20));
        end else begin
          // noise: any command code with random fields
          repeat ($urandom_range(15, 4)) begin
            b = fresh_beat(CMD_TICK);
            if ($urandom_range(99) < 50) b.cmd = 3'($urandom);
            issue(b);
          end
        end
      end
    end

    // Wait for the last results, bounded
    in_valid <= 1'b0;
    @(posedge clk);
    for (wait_cycles = 0; outstanding != 0 && wait_cycles < 2000; wait_cycles++)
      @(posedge clk);
    leftover = (outstanding != 0);
    if (leftover) $display("ERROR: %0d result beats never arrived", outstanding);
    repeat (4) @(posedge clk);

    $display("Summary: %0d command beats incl. %0d sequence starts, %0d note ends checked,",
             beats_sent, starts_sent, note_ends);
    $display("         pin pair drive both off and on, with a long result hold-off.");
    if (fail_count == 0 && !leftover) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
